>>> rtl/core/jdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdc_pkg
// Constants, reciprocal multipliers and shared types of the Julian day
// converter core.
// ----------------------------------------------------------------------------
package jdc_pkg;

   // pipeline depth, input register to result register
   localparam int unsigned PIPE_STAGES = 9;

   // supported input ranges
   localparam logic signed [14:0] YEAR_MIN = -15'sd4712;
   localparam logic signed [14:0] YEAR_MAX = 15'sd9999;
   localparam logic signed [14:0] YEAR_GREG = 15'sd1582;
   localparam logic [22:0] DAYNUM_MAX = 23'd5373484;
   localparam logic [16:0] SECS_MAX = 17'd86399;

   // first day number of the gregorian calendar (1582-10-15)
   localparam logic [22:0] GREG_START_DAY = 23'd2299161;
   // 1867216.25 scaled by four
   localparam logic [24:0] CYC_OFFSET = 25'd7468865;

   // actions
   localparam logic ACT_DATE_TO_DAY = 1'b0;
   localparam logic ACT_DAY_TO_DATE = 1'b1;

   // floor division by constants as multiply and shift
   // divide by 100 (century of the year), exact below 16384
   localparam int unsigned CENTURY_SHIFT = 19;
   localparam logic [12:0] CENTURY_RECIP =
      13'(((64'd1 << CENTURY_SHIFT) + 64'd99) / 64'd100);
   // divide by 146097 (gregorian century in quarter days)
   localparam int unsigned CYC_SHIFT = 42;
   localparam logic [24:0] CYC_RECIP =
      25'(((64'd1 << CYC_SHIFT) + 64'd146096) / 64'd146097);
   // divide by 36525 (julian year in hundredths of days)
   localparam int unsigned YEAR_SHIFT = 46;
   localparam logic [30:0] YEAR_RECIP =
      31'(((64'd1 << YEAR_SHIFT) + 64'd36524) / 64'd36525);
   // multiply by 10000 / 306001 (month length 30.6001 days)
   localparam int unsigned MON_SHIFT = 40;
   localparam logic [35:0] MON_RECIP =
      36'(((64'd1 << MON_SHIFT) * 64'd10000 + 64'd306000) / 64'd306001);
   // divide by 3600 and by 60
   localparam int unsigned HOUR_SHIFT = 30;
   localparam logic [18:0] HOUR_RECIP =
      19'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);
   localparam int unsigned MIN_SHIFT = 20;
   localparam logic [14:0] MIN_RECIP =
      15'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

   // control that travels with each item
   typedef struct packed {
      logic valid;
      logic action;
      logic err;
   } ctl_type;

   // floor(30.6001 * k) for month index k of the march based year
   function automatic logic [8:0] month_offset(input logic [3:0] k);
      logic [8:0] res;
      case (k)
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd183;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd244;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd336;
         4'd12:   res = 9'd367;
         4'd13:   res = 9'd397;
         4'd14:   res = 9'd428;
         4'd15:   res = 9'd459;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/core/julian_day_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_converter_core
// Calendar date and time to civil day number and back, Meeus method with the
// gregorian switch at 1582-10-15.
// ----------------------------------------------------------------------------
// The core is a nine stage pipeline: a command is taken in every cycle in
// which start is high, busy never rises, and its result appears on the rsp_
// ports with rsp_valid from the result register, for one cycle only, in
// command order. The depth is set by the day number to date path, which
// needs three reciprocal multiplies and two constant multiplies in a row,
// each followed by a register.
// The receiver cannot stall, so it must take every result strobe. Results
// of the other action read as zero; with rsp_range_error high all other
// result fields are zero.
// ----------------------------------------------------------------------------
module julian_day_converter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic signed [14:0] req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic [4:0]         req_hour,
   input  logic [5:0]         req_minute,
   input  logic [5:0]         req_second,
   input  logic [22:0]        req_day_number,
   input  logic [16:0]        req_seconds_of_day,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_out_year,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic [4:0]         rsp_out_hour,
   output logic [5:0]         rsp_out_minute,
   output logic [5:0]         rsp_out_second,
   output logic [22:0]        rsp_out_day_number,
   output logic [16:0]        rsp_out_seconds_of_day,
   output logic               rsp_range_error
);
   import jdc_pkg::*;

   // control shift line
   ctl_type ctl_ff [PIPE_STAGES];
   ctl_type ctl_in;

   // stage 1
   logic        range0, range1, greg0, greg1, mlow;
   logic [15:0] y_adj, y_off;
   logic [16:0] secs0;
   logic [24:0] z4_off;
   logic [13:0] s1_y_off_in, s1_y_off_ff, s1_yc_in, s1_yc_ff;
   logic [3:0]  s1_mk_in, s1_mk_ff;
   logic [4:0]  s1_day_in, s1_day_ff;
   logic        s1_greg_in, s1_greg_ff;
   logic [16:0] s1_secs_in, s1_secs_ff;
   logic [22:0] s1_z_in, s1_z_ff;
   logic [23:0] s1_xcyc_in, s1_xcyc_ff;

   // stage 2
   logic [24:0] yd_prod;
   logic [26:0] cent_prod;
   logic [48:0] cyc_prod;
   logic [35:0] hour_prod;
   logic [22:0] s2_yd_in, s2_yd_ff;
   logic [7:0]  s2_cent_in, s2_cent_ff;
   logic [8:0]  s2_md_in, s2_md_ff;
   logic [4:0]  s2_day_in, s2_day_ff;
   logic        s2_greg_in, s2_greg_ff;
   logic [16:0] s2_secs_in, s2_secs_ff;
   logic [22:0] s2_z_in, s2_z_ff;
   logic [6:0]  s2_cyc_in, s2_cyc_ff;
   logic [4:0]  s2_hour_in, s2_hour_ff;

   // stage 3
   logic [22:0] corr, gcorr;
   logic [16:0] rem_full;
   logic [22:0] s3_dn_in, s3_dn_ff, s3_b_in, s3_b_ff;
   logic [11:0] s3_rem_in, s3_rem_ff;
   logic [16:0] s3_secs_in, s3_secs_ff;
   logic [4:0]  s3_hour_in, s3_hour_ff;

   // stage 4
   logic [26:0] min_prod;
   logic [29:0] s4_xc_in, s4_xc_ff;
   logic [22:0] s4_dn_ff, s4_b_ff;
   logic [11:0] s4_rem_ff;
   logic [16:0] s4_secs_ff;
   logic [4:0]  s4_hour_ff;
   logic [5:0]  s4_minute_in, s4_minute_ff;

   // stage 5
   logic [60:0] c_prod;
   logic [11:0] sec_full;
   logic [13:0] s5_c_in, s5_c_ff;
   logic [5:0]  s5_second_in, s5_second_ff;
   logic [22:0] s5_dn_ff, s5_b_ff;
   logic [16:0] s5_secs_ff;
   logic [4:0]  s5_hour_ff;
   logic [5:0]  s5_minute_ff;

   // stage 6
   logic [24:0] d_prod;
   logic [22:0] s6_d_in, s6_d_ff;
   logic [14:0] s6_yr0_in, s6_yr0_ff;
   logic [22:0] s6_dn_ff, s6_b_ff;
   logic [16:0] s6_secs_ff;
   logic [4:0]  s6_hour_ff;
   logic [5:0]  s6_minute_ff, s6_second_ff;

   // stage 7
   logic [22:0] bd_full;
   logic [9:0]  s7_bd_in, s7_bd_ff;
   logic [14:0] s7_yr0_ff;
   logic [22:0] s7_dn_ff;
   logic [16:0] s7_secs_ff;
   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_minute_ff, s7_second_ff;

   // stage 8
   logic [45:0] e_prod;
   logic [3:0]  s8_e_in, s8_e_ff;
   logic [9:0]  s8_bd_ff;
   logic [14:0] s8_yr0_ff;
   logic [22:0] s8_dn_ff;
   logic [16:0] s8_secs_ff;
   logic [4:0]  s8_hour_ff;
   logic [5:0]  s8_minute_ff, s8_second_ff;

   // result stage
   logic [9:0]  dom_full;
   logic [3:0]  mon;
   logic [14:0] yr;
   logic [14:0] out_year_in, out_year_ff;
   logic [3:0]  out_month_in, out_month_ff;
   logic [4:0]  out_day_in, out_day_ff;
   logic [4:0]  out_hour_in, out_hour_ff;
   logic [5:0]  out_minute_in, out_minute_ff;
   logic [5:0]  out_second_in, out_second_ff;
   logic [22:0] out_dn_in, out_dn_ff;
   logic [16:0] out_secs_in, out_secs_ff;

   // every cycle is open for a transfer
   assign busy = 1'b0;

   // stage 1: range checks, gregorian flag, march based year and month, seconds of day, day number offset
   always_comb begin
      range0 = (req_year < YEAR_MIN) || (req_year > YEAR_MAX) ||
               (req_month < 4'd1) || (req_month > 4'd12) ||
               (req_day < 5'd1) || (req_hour > 5'd23) ||
               (req_minute > 6'd59) || (req_second > 6'd59);
      range1 = (req_day_number > DAYNUM_MAX) || (req_seconds_of_day > SECS_MAX);
      greg0  = (req_year > YEAR_GREG) ||
               ((req_year == YEAR_GREG) && ((req_month > 4'd10) ||
                ((req_month == 4'd10) && (req_day >= 5'd15))));
      greg1  = req_day_number >= GREG_START_DAY;
      mlow   = req_month < 4'd3;
      y_adj  = 16'(req_year) - {15'd0, mlow};
      y_off  = y_adj + 16'd4716;
      secs0  = 17'(req_hour) * 17'd3600 + 17'(req_minute) * 17'd60 +
               17'(req_second);
      z4_off = {req_day_number, 2'b00} - CYC_OFFSET;

      ctl_in.valid  = start;
      ctl_in.action = req_action;
      ctl_in.err    = (req_action == ACT_DAY_TO_DATE) ? range1 : range0;

      s1_y_off_in = y_off[13:0];
      s1_yc_in    = y_adj[13:0];
      s1_mk_in    = req_month + (mlow ? 4'd13 : 4'd1);
      s1_day_in   = req_day;
      s1_greg_in  = (req_action == ACT_DAY_TO_DATE) ? greg1 : greg0;
      s1_secs_in  = (req_action == ACT_DAY_TO_DATE) ? req_seconds_of_day : secs0;
      s1_z_in     = req_day_number;
      s1_xcyc_in  = z4_off[23:0];
   end

   // stage 2: year days, century, month offset, gregorian centuries, hour
   always_comb begin
      yd_prod   = 25'(s1_y_off_ff) * 25'd1461;
      cent_prod = 27'(s1_yc_ff) * 27'(CENTURY_RECIP);
      cyc_prod  = 49'(s1_xcyc_ff) * 49'(CYC_RECIP);
      hour_prod = 36'(s1_secs_ff) * 36'(HOUR_RECIP);

      s2_yd_in   = yd_prod[24:2];
      s2_cent_in = cent_prod[CENTURY_SHIFT +: 8];
      s2_md_in   = month_offset(s1_mk_ff);
      s2_day_in  = s1_day_ff;
      s2_greg_in = s1_greg_ff;
      s2_secs_in = s1_secs_ff;
      s2_z_in    = s1_z_ff;
      s2_cyc_in  = cyc_prod[CYC_SHIFT +: 7];
      s2_hour_in = hour_prod[HOUR_SHIFT +: 5];
   end

   // stage 3: day number sum, gregorian corrected day count, seconds past hour
   always_comb begin
      corr  = s2_greg_ff ? (23'd2 - 23'(s2_cent_ff) + 23'(s2_cent_ff[7:2])) : 23'd0;
      gcorr = s2_greg_ff ? (23'd1 + 23'(s2_cyc_ff) - 23'(s2_cyc_ff[6:2])) : 23'd0;
      rem_full = s2_secs_ff - 17'(s2_hour_ff) * 17'd3600;

      s3_dn_in   = s2_yd_ff + 23'(s2_md_ff) + 23'(s2_day_ff) + corr - 23'd1524;
      s3_b_in    = s2_z_ff + 23'd1524 + gcorr;
      s3_rem_in  = rem_full[11:0];
      s3_secs_in = s2_secs_ff;
      s3_hour_in = s2_hour_ff;
   end

   // stage 4: scaled day count for the year divide, minute
   always_comb begin
      min_prod     = 27'(s3_rem_ff) * 27'(MIN_RECIP);
      s4_xc_in     = 30'(s3_b_ff) * 30'd100 - 30'd12210;
      s4_minute_in = min_prod[MIN_SHIFT +: 6];
   end

   // stage 5: julian years, second
   always_comb begin
      c_prod       = 61'(s4_xc_ff) * 61'(YEAR_RECIP);
      sec_full     = s4_rem_ff - 12'(s4_minute_ff) * 12'd60;
      s5_c_in      = c_prod[YEAR_SHIFT +: 14];
      s5_second_in = sec_full[5:0];
   end

   // stage 6: days in whole years, year before month fixup
   always_comb begin
      d_prod    = 25'(s5_c_ff) * 25'd1461;
      s6_d_in   = d_prod[24:2];
      s6_yr0_in = 15'(s5_c_ff) - 15'd4715;
   end

   // stage 7: day of the march based year
   always_comb begin
      bd_full  = s6_b_ff - s6_d_ff;
      s7_bd_in = bd_full[9:0];
   end

   // stage 8: march based month
   always_comb begin
      e_prod  = 46'(s7_bd_ff) * 46'(MON_RECIP);
      s8_e_in = e_prod[MON_SHIFT +: 4];
   end

   // result stage: day of month, month, year, and field selection
   always_comb begin
      dom_full = s8_bd_ff - 10'(month_offset(s8_e_ff));
      mon      = (s8_e_ff < 4'd14) ? (s8_e_ff - 4'd1) : (s8_e_ff - 4'd13);
      yr       = s8_yr0_ff - {14'd0, (mon > 4'd2)};

      out_year_in   = '0;
      out_month_in  = '0;
      out_day_in    = '0;
      out_hour_in   = '0;
      out_minute_in = '0;
      out_second_in = '0;
      out_dn_in     = '0;
      out_secs_in   = '0;
      if (!ctl_ff[PIPE_STAGES-2].err) begin
         if (ctl_ff[PIPE_STAGES-2].action == ACT_DAY_TO_DATE) begin
            out_year_in   = yr;
            out_month_in  = mon;
            out_day_in    = dom_full[4:0];
            out_hour_in   = s8_hour_ff;
            out_minute_in = s8_minute_ff;
            out_second_in = s8_second_ff;
         end else begin
            out_dn_in   = s8_dn_ff;
            out_secs_in = s8_secs_ff;
         end
      end
   end

   // control: valid, action and range flag travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < PIPE_STAGES; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // payload registers of all stages
   always_ff @(posedge clock) begin
      s1_y_off_ff <= s1_y_off_in;
      s1_yc_ff    <= s1_yc_in;
      s1_mk_ff    <= s1_mk_in;
      s1_day_ff   <= s1_day_in;
      s1_greg_ff  <= s1_greg_in;
      s1_secs_ff  <= s1_secs_in;
      s1_z_ff     <= s1_z_in;
      s1_xcyc_ff  <= s1_xcyc_in;

      s2_yd_ff   <= s2_yd_in;
      s2_cent_ff <= s2_cent_in;
      s2_md_ff   <= s2_md_in;
      s2_day_ff  <= s2_day_in;
      s2_greg_ff <= s2_greg_in;
      s2_secs_ff <= s2_secs_in;
      s2_z_ff    <= s2_z_in;
      s2_cyc_ff  <= s2_cyc_in;
      s2_hour_ff <= s2_hour_in;

      s3_dn_ff   <= s3_dn_in;
      s3_b_ff    <= s3_b_in;
      s3_rem_ff  <= s3_rem_in;
      s3_secs_ff <= s3_secs_in;
      s3_hour_ff <= s3_hour_in;

      s4_xc_ff     <= s4_xc_in;
      s4_dn_ff     <= s3_dn_ff;
      s4_b_ff      <= s3_b_ff;
      s4_rem_ff    <= s3_rem_ff;
      s4_secs_ff   <= s3_secs_ff;
      s4_hour_ff   <= s3_hour_ff;
      s4_minute_ff <= s4_minute_in;

      s5_c_ff      <= s5_c_in;
      s5_second_ff <= s5_second_in;
      s5_dn_ff     <= s4_dn_ff;
      s5_b_ff      <= s4_b_ff;
      s5_secs_ff   <= s4_secs_ff;
      s5_hour_ff   <= s4_hour_ff;
      s5_minute_ff <= s4_minute_ff;

      s6_d_ff      <= s6_d_in;
      s6_yr0_ff    <= s6_yr0_in;
      s6_dn_ff     <= s5_dn_ff;
      s6_b_ff      <= s5_b_ff;
      s6_secs_ff   <= s5_secs_ff;
      s6_hour_ff   <= s5_hour_ff;
      s6_minute_ff <= s5_minute_ff;
      s6_second_ff <= s5_second_ff;

      s7_bd_ff     <= s7_bd_in;
      s7_yr0_ff    <= s6_yr0_ff;
      s7_dn_ff     <= s6_dn_ff;
      s7_secs_ff   <= s6_secs_ff;
      s7_hour_ff   <= s6_hour_ff;
      s7_minute_ff <= s6_minute_ff;
      s7_second_ff <= s6_second_ff;

      s8_e_ff      <= s8_e_in;
      s8_bd_ff     <= s7_bd_ff;
      s8_yr0_ff    <= s7_yr0_ff;
      s8_dn_ff     <= s7_dn_ff;
      s8_secs_ff   <= s7_secs_ff;
      s8_hour_ff   <= s7_hour_ff;
      s8_minute_ff <= s7_minute_ff;
      s8_second_ff <= s7_second_ff;

      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
      out_dn_ff     <= out_dn_in;
      out_secs_ff   <= out_secs_in;
   end

   // result transfer ports
   assign rsp_valid              = ctl_ff[PIPE_STAGES-1].valid;
   assign rsp_range_error        = ctl_ff[PIPE_STAGES-1].err;
   assign rsp_out_year           = out_year_ff;
   assign rsp_out_month          = out_month_ff;
   assign rsp_out_day            = out_day_ff;
   assign rsp_out_hour           = out_hour_ff;
   assign rsp_out_minute         = out_minute_ff;
   assign rsp_out_second         = out_second_ff;
   assign rsp_out_day_number     = out_dn_ff;
   assign rsp_out_seconds_of_day = out_secs_ff;

endmodule

>>> tb/julian_day_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_converter_core_tb
// Self-checking bench for the Julian day converter core. It sends directed
// commands (range limits, the calendar switch, out of range fields), then
// about two thousand random date and day number commands with random idle
// gaps. Every result is checked against a behavioral model of the
// conversions.
// ----------------------------------------------------------------------------
module julian_day_converter_core_tb;
   import jdc_pkg::*;

   localparam int RANDOM_CMDS    = 1925;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int MAX_IDLE       = 13;

   // one command with its sender idle gap and drain hold-off
   typedef struct {
      logic               action;
      logic signed [14:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [22:0]        day_number;
      logic [16:0]        seconds_of_day;
      int                 gap;
      bit                 drain_first;
   } convert_cmd_type;

   // one conversion result
   typedef struct {
      logic signed [14:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [22:0]        day_number;
      logic [16:0]        seconds_of_day;
      logic               range_error;
   } convert_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = 1'b0;
   logic signed [14:0] req_year = '0;
   logic [3:0]         req_month = '0;
   logic [4:0]         req_day = '0;
   logic [4:0]         req_hour = '0;
   logic [5:0]         req_minute = '0;
   logic [5:0]         req_second = '0;
   logic [22:0]        req_day_number = '0;
   logic [16:0]        req_seconds_of_day = '0;
   logic               rsp_valid;
   logic signed [14:0] rsp_out_year;
   logic [3:0]         rsp_out_month;
   logic [4:0]         rsp_out_day;
   logic [4:0]         rsp_out_hour;
   logic [5:0]         rsp_out_minute;
   logic [5:0]         rsp_out_second;
   logic [22:0]        rsp_out_day_number;
   logic [16:0]        rsp_out_seconds_of_day;
   logic               rsp_range_error;

   convert_cmd_type cmd_queue[$];
   convert_rsp_type predicted_conversions[$];

   bit xfer_hit = 1'b0;
   bit no_idle = 1'b0;
   int idle_count = 0;
   int stall_cycles = 0;
   int fail_count = 0;
   int date_cmds = 0;
   int daynum_cmds = 0;
   int range_errs = 0;
   int results_checked = 0;

   julian_day_converter_core u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_year               (req_year),
      .req_month              (req_month),
      .req_day                (req_day),
      .req_hour               (req_hour),
      .req_minute             (req_minute),
      .req_second             (req_second),
      .req_day_number         (req_day_number),
      .req_seconds_of_day     (req_seconds_of_day),
      .rsp_valid              (rsp_valid),
      .rsp_out_year           (rsp_out_year),
      .rsp_out_month          (rsp_out_month),
      .rsp_out_day            (rsp_out_day),
      .rsp_out_hour           (rsp_out_hour),
      .rsp_out_minute         (rsp_out_minute),
      .rsp_out_second         (rsp_out_second),
      .rsp_out_day_number     (rsp_out_day_number),
      .rsp_out_seconds_of_day (rsp_out_seconds_of_day),
      .rsp_range_error        (rsp_range_error)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // expected result of one command, all divisions on non-negative values
   function automatic convert_rsp_type predict_conversion(convert_cmd_type c);
      convert_rsp_type r;
      longint y, m, d, corr, cent, dn;
      longint z, s, a, cyc, b, cy, cd, e, dom, mon, yr;
      bit greg;
      r = '{default: '0};
      if (c.action == ACT_DATE_TO_DAY) begin
         y = c.year;
         m = c.month;
         d = c.day;
         if (c.year < YEAR_MIN || c.year > YEAR_MAX || m < 1 || m > 12 || d < 1 ||
             c.hour > 23 || c.minute > 59 || c.second > 59) begin
            r.range_error = 1'b1;
            return r;
         end
         // dates up to 1582-10-14 count as julian
         greg = (y > 1582) || (y == 1582 && m > 10) || (y == 1582 && m == 10 && d >= 15);
         // january and february belong to the previous year
         if (m < 3) begin
            y = y - 1;
            m = m + 12;
         end
         corr = 0;
         if (greg) begin
            cent = y / 100;
            corr = 2 - cent + cent / 4;
         end
         dn = corr + (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + d - 1524;
         r.day_number = 23'(dn);
         r.seconds_of_day = 17'(longint'(c.hour) * 3600 + longint'(c.minute) * 60 +
                                longint'(c.second));
      end else begin
         z = c.day_number;
         s = c.seconds_of_day;
         if (c.day_number > DAYNUM_MAX || c.seconds_of_day > SECS_MAX) begin
            r.range_error = 1'b1;
            return r;
         end
         // gregorian correction from 1582-10-15 on
         a = z;
         if (c.day_number >= GREG_START_DAY) begin
            cyc = (4 * z - 7468865) / 146097;
            a = z + 1 + cyc - cyc / 4;
         end
         b = a + 1524;
         cy = (100 * b - 12210) / 36525;
         cd = (1461 * cy) / 4;
         e = (10000 * (b - cd)) / 306001;
         dom = b - cd - (306001 * e) / 10000;
         mon = (e < 14) ? e - 1 : e - 13;
         yr = cy - 4715;
         if (mon > 2) yr = yr - 1;
         r.year = 15'(yr);
         r.month = 4'(mon);
         r.day = 5'(dom);
         r.hour = 5'(s / 3600);
         r.minute = 6'((s % 3600) / 60);
         r.second = 6'(s % 60);
      end
      return r;
   endfunction

   // command with every field random, fields of the other action included
   function automatic convert_cmd_type random_cmd();
      convert_cmd_type c;
      c.action = 1'($urandom);
      c.year = 15'($urandom);
      c.month = 4'($urandom);
      c.day = 5'($urandom);
      c.hour = 5'($urandom);
      c.minute = 6'($urandom);
      c.second = 6'($urandom);
      c.day_number = 23'($urandom);
      c.seconds_of_day = 17'($urandom);
      c.gap = 0;
      c.drain_first = 1'b0;
      return c;
   endfunction

   task automatic queue_cmd(convert_cmd_type c);
      c.gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
      cmd_queue.push_back(c);
   endtask

   task automatic queue_date(int y, int mo, int d, int h, int mi, int s);
      convert_cmd_type c;
      c = random_cmd();
      c.action = ACT_DATE_TO_DAY;
      c.year = 15'(y);
      c.month = 4'(mo);
      c.day = 5'(d);
      c.hour = 5'(h);
      c.minute = 6'(mi);
      c.second = 6'(s);
      queue_cmd(c);
   endtask

   task automatic queue_daynum(int z, int s);
      convert_cmd_type c;
      c = random_cmd();
      c.action = ACT_DAY_TO_DATE;
      c.day_number = 23'(z);
      c.seconds_of_day = 17'(s);
      queue_cmd(c);
   endtask

   task automatic report_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic signed [63:0] want_v,
                              logic signed [63:0] got_v);
      if (got_v !== want_v)
         report_fail($sformatf("%s expected %0d got %0d", name, want_v, got_v));
   endtask

   // command driver, one transfer per accepted start
   always @(negedge clock) begin
      convert_cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !xfer_hit) begin
         // hold the command until it is taken
      end else if (cmd_queue.size() == 0) begin
         start <= 1'b0;
      end else if (idle_count < cmd_queue[0].gap ||
                   (cmd_queue[0].drain_first && predicted_conversions.size() != 0)) begin
         start <= 1'b0;
         idle_count++;
      end else begin
         c = cmd_queue.pop_front();
         idle_count = 0;
         req_action <= c.action;
         req_year <= c.year;
         req_month <= c.month;
         req_day <= c.day;
         req_hour <= c.hour;
         req_minute <= c.minute;
         req_second <= c.second;
         req_day_number <= c.day_number;
         req_seconds_of_day <= c.seconds_of_day;
         start <= 1'b1;
      end
   end

   // result checker and command capture
   always @(posedge clock) begin
      convert_cmd_type c;
      convert_rsp_type want;
      if (reset) begin
         xfer_hit <= 1'b0;
      end else begin
         // results come out in command order
         if (rsp_valid) begin
            if (predicted_conversions.size() == 0) begin
               report_fail("result transfer with no command outstanding");
            end else begin
               want = predicted_conversions.pop_front();
               results_checked++;
               check_field("out_year", want.year, rsp_out_year);
               check_field("out_month", want.month, rsp_out_month);
               check_field("out_day", want.day, rsp_out_day);
               check_field("out_hour", want.hour, rsp_out_hour);
               check_field("out_minute", want.minute, rsp_out_minute);
               check_field("out_second", want.second, rsp_out_second);
               check_field("out_day_number", want.day_number, rsp_out_day_number);
               check_field("out_seconds_of_day", want.seconds_of_day,
                           rsp_out_seconds_of_day);
               check_field("range_error", want.range_error, rsp_range_error);
            end
         end
         // command transfer
         xfer_hit <= start && !busy;
         if (start && !busy) begin
            c.action = req_action;
            c.year = req_year;
            c.month = req_month;
            c.day = req_day;
            c.hour = req_hour;
            c.minute = req_minute;
            c.second = req_second;
            c.day_number = req_day_number;
            c.seconds_of_day = req_seconds_of_day;
            want = predict_conversion(c);
            predicted_conversions.push_back(want);
            if (c.action == ACT_DATE_TO_DAY) date_cmds++;
            else daynum_cmds++;
            if (want.range_error) range_errs++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("julian_day_converter_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      convert_cmd_type c;
      int pick;

      // range limits and the calendar switch
      queue_date(-4712, 1, 1, 0, 0, 0);
      queue_date(9999, 12, 31, 23, 59, 59);
      queue_date(1582, 10, 4, 12, 30, 45);
      queue_date(1582, 10, 10, 6, 0, 0);
      queue_date(1582, 10, 15, 0, 0, 1);
      queue_date(1583, 2, 28, 18, 15, 30);
      // day past the month length is accepted
      queue_date(1600, 2, 31, 1, 2, 3);
      // out of range date fields
      queue_date(-4713, 6, 15, 0, 0, 0);
      queue_date(10000, 6, 15, 0, 0, 0);
      queue_date(-16384, 0, 1, 0, 0, 0);
      queue_date(16383, 13, 1, 0, 0, 0);
      queue_date(2000, 15, 0, 0, 0, 0);
      queue_date(2000, 1, 1, 24, 0, 0);
      queue_date(2000, 1, 1, 31, 63, 63);
      queue_date(2000, 1, 1, 0, 60, 0);
      queue_date(2000, 1, 1, 0, 0, 60);
      // day number limits and the first gregorian day
      queue_daynum(0, 0);
      queue_daynum(5373484, 86399);
      queue_daynum(2299160, 43200);
      queue_daynum(2299161, 1);
      queue_daynum(2451545, 0);
      // out of range day number fields
      queue_daynum(5373485, 0);
      queue_daynum(8388607, 131071);
      queue_daynum(12345, 86400);

      // random commands, mostly in range
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         if (i % 150 == 0) no_idle = ($urandom_range(2, 0) == 0);
         c = random_cmd();
         pick = $urandom_range(99, 0);
         if (pick < 45) begin
            c.action = ACT_DATE_TO_DAY;
            c.year = 15'(int'($urandom_range(14711, 0)) - 4712);
            c.month = 4'($urandom_range(12, 1));
            c.day = 5'($urandom_range(31, 1));
            c.hour = 5'($urandom_range(23, 0));
            c.minute = 6'($urandom_range(59, 0));
            c.second = 6'($urandom_range(59, 0));
            case ($urandom_range(9, 0))
               0: begin
                  // around the calendar switch
                  c.year = YEAR_GREG;
                  c.month = 4'($urandom_range(12, 9));
               end
               1: c.year = 15'(int'($urandom_range(12, 0)) - 4712);
               2: c.year = 15'(int'($urandom_range(12, 0)) + 9987);
               default: ;
            endcase
         end else if (pick < 90) begin
            c.action = ACT_DAY_TO_DATE;
            c.day_number = 23'($urandom_range(5373484, 0));
            c.seconds_of_day = 17'($urandom_range(86399, 0));
            case ($urandom_range(9, 0))
               0: c.day_number = 23'(2298761 + $urandom_range(800, 0));
               1: c.day_number = 23'($urandom_range(2000, 0));
               2: c.day_number = 23'(5371484 + $urandom_range(2000, 0));
               default: ;
            endcase
         end
         // drain the pipe before the random part and half way through
         c.drain_first = (i == 0) || (i == RANDOM_CMDS / 2);
         queue_cmd(c);
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (cmd_queue.size() != 0 || start) @(posedge clock);
      while (predicted_conversions.size() != 0) @(negedge clock);
      repeat (PIPE_STAGES + 4) @(posedge clock);

      $display("covered %0d date to day number and %0d day number to date commands",
               date_cmds, daynum_cmds);
      $display("%0d of them out of range, %0d results checked, %0d failures",
               range_errs, results_checked, fail_count);
      if (fail_count == 0) begin
         $display("julian_day_converter_core: match");
      end else begin
         $display("julian_day_converter_core: mismatch");
      end
      $finish;
   end

endmodule
